/* hw/rtl/lph_pkg.sv */
// Shared types and constants for the linear probing hash table.
// No dependencies.
package lph_pkg;
  localparam int unsigned SLOTS_DEF        = 1024;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;
  localparam int unsigned CFG_W            = 11;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned HASH_MULT        = 31;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [CFG_W-1:0] CAP_RESET   = 11'd1024;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd768;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_LIMIT    = 1'b1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_HASH,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_CLEAR,
    BE_IDLE,
    BE_READ,
    BE_CHECK,
    BE_DONE
  } be_state_t;
endpackage

/* hw/rtl/lph_front.sv */
// Front end: takes a command and computes its home slot, one key byte per cycle.
// Depends on lph_pkg.
module lph_front import lph_pkg::*; #(
  parameter int unsigned SLOTS        = SLOTS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int unsigned IDX_W       = $clog2(SLOTS),
  localparam int unsigned CNT_W       = $clog2(SLOTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    fe_ready,
  input  logic                    in_operation,
  input  logic [KEY_W-1:0]        in_key,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [CNT_W-1:0]        cap,
  output logic                    q_push,
  input  logic                    q_full,
  output logic                    q_op,
  output logic [KEY_W-1:0]        q_key,
  output logic [PAYLOAD_BITS-1:0] q_payload,
  output logic [IDX_W-1:0]        q_home
);
  fe_state_t               state_r, state_nxt;
  logic [1:0]              byte_r;
  logic [CNT_W-1:0]        h_r;
  logic                    op_r;
  logic [KEY_W-1:0]        key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [CNT_W+7:0]        prod;
  logic [CNT_W+7:0]        rem;
  logic [7:0]              kbyte;

  // h*31+b < 256*cap; reduce with up to 8 conditional subtracts of cap<<k
  always_comb begin
    kbyte = key_r[8*byte_r +: 8];
    prod  = ({8'd0, h_r} << 5) - {8'd0, h_r} + (CNT_W+8)'(kbyte);
    rem   = prod;
    for (int k = 7; k >= 0; k--) begin
      if (rem >= ({8'd0, cap} << k)) rem = rem - ({8'd0, cap} << k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      byte_r  <= '0;
      h_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FE_IDLE && start) begin
        op_r   <= in_operation;
        key_r  <= in_key;
        pay_r  <= in_payload;
        byte_r <= '0;
        h_r    <= '0;
      end else if (state_r == FE_HASH) begin
        h_r    <= rem[CNT_W-1:0];
        byte_r <= byte_r + 2'd1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    fe_ready  = 1'b0;
    q_push    = 1'b0;
    unique case (state_r)
      FE_IDLE: begin
        fe_ready = 1'b1;
        if (start) state_nxt = FE_HASH;
      end
      FE_HASH: if (byte_r == 2'd3) state_nxt = FE_PUSH;
      FE_PUSH: if (!q_full) begin
        q_push    = 1'b1;
        state_nxt = FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  assign q_op      = op_r;
  assign q_key     = key_r;
  assign q_payload = pay_r;
  assign q_home    = h_r[IDX_W-1:0];
endmodule

/* hw/rtl/lph_queue.sv */
// Short command queue between hash front end and probe back end.
// Depends on lph_pkg.
module lph_queue import lph_pkg::*; #(
  parameter int unsigned SLOTS        = SLOTS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int unsigned IDX_W       = $clog2(SLOTS),
  localparam int unsigned W           = 1 + KEY_W + PAYLOAD_BITS + IDX_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] mem_r [QUEUE_DEPTH];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assign rdata = mem_r[rp_r];
  assign full  = (cnt_r == 2'(QUEUE_DEPTH));
  assign empty = (cnt_r == 2'd0);
endmodule

/* hw/rtl/lph_back.sv */
// Back end: clears valid bits, walks the probe sequence and updates the table.
// Depends on lph_pkg.
module lph_back import lph_pkg::*; #(
  parameter int unsigned SLOTS        = SLOTS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int unsigned IDX_W       = $clog2(SLOTS),
  localparam int unsigned CNT_W       = $clog2(SLOTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CNT_W-1:0]        cap,
  input  logic [CFG_W-1:0]        load_limit,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  logic                    q_op,
  input  logic [KEY_W-1:0]        q_key,
  input  logic [PAYLOAD_BITS-1:0] q_payload,
  input  logic [IDX_W-1:0]        q_home,
  output logic                    clearing,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [63:0]             out_found_payload,
  output logic [9:0]              out_slot
);
  be_state_t               state_r, state_nxt;
  logic [KEY_W-1:0]        key_mem [SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
  logic                    vld_mem [SLOTS];
  logic [KEY_W-1:0]        rd_key_r;
  logic [PAYLOAD_BITS-1:0] rd_pay_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        s_r, clr_r;
  logic [CNT_W-1:0]        n_r;
  logic [CFG_W-1:0]        count_r;
  logic                    op_r;
  logic [KEY_W-1:0]        key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [2:0]              st_r;
  logic [PAYLOAD_BITS-1:0] fp_r;
  logic [IDX_W-1:0]        slot_r;
  logic                    hit, do_write, do_ins;
  logic [CNT_W-1:0]        s_inc;

  assign hit      = !rd_vld_r || (rd_key_r == key_r);
  assign s_inc    = CNT_W'(s_r) + 1'b1;
  assign do_write = (state_r == BE_CHECK) && hit && (op_r == OP_INSERT) &&
                    (rd_vld_r || (count_r < load_limit));
  assign do_ins   = do_write && !rd_vld_r;

  always_ff @(posedge clk) begin
    if (state_r == BE_CLEAR) vld_mem[clr_r] <= 1'b0;
    else if (do_ins)         vld_mem[s_r]   <= 1'b1;
    if (do_write) begin
      pay_mem[s_r] <= pay_r;
      if (do_ins) key_mem[s_r] <= key_r;
    end
    rd_key_r <= key_mem[s_r];
    rd_pay_r <= pay_mem[s_r];
    rd_vld_r <= vld_mem[s_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BE_CLEAR) clr_r <= clr_r + 1'b1;
      if (do_ins) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r  <= q_op;
      key_r <= q_key;
      pay_r <= q_payload;
      s_r   <= q_home;
      n_r   <= '0;
    end else if (state_r == BE_CHECK && !hit) begin
      s_r <= (s_inc >= cap) ? '0 : s_inc[IDX_W-1:0];
      n_r <= n_r + 1'b1;
    end
    if (state_r == BE_CHECK) begin
      fp_r   <= '0;
      slot_r <= '0;
      if (hit && rd_vld_r) begin
        slot_r <= s_r;
        if (op_r == OP_LOOKUP) begin
          st_r <= ST_FOUND;
          fp_r <= rd_pay_r;
        end else begin
          st_r <= ST_UPDATED;
          fp_r <= pay_r;
        end
      end else if (hit && op_r == OP_INSERT && count_r < load_limit) begin
        st_r   <= ST_INSERTED;
        slot_r <= s_r;
      end else if (op_r == OP_LOOKUP) begin
        st_r <= ST_NOT_FOUND;
      end else begin
        st_r <= ST_FULL;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BE_CLEAR: if (clr_r == IDX_W'(SLOTS - 1)) state_nxt = BE_IDLE;
      BE_IDLE: if (!q_empty) begin
        q_pop     = 1'b1;
        state_nxt = BE_READ;
      end
      BE_READ:  state_nxt = BE_CHECK;
      BE_CHECK: begin
        if (hit || n_r + 1'b1 >= cap) state_nxt = BE_DONE;
        else                          state_nxt = BE_READ;
      end
      BE_DONE:  state_nxt = BE_IDLE;
      default:  state_nxt = BE_IDLE;
    endcase
  end

  assign clearing          = (state_r == BE_CLEAR);
  assign out_valid         = (state_r == BE_DONE);
  assign out_status        = st_r;
  assign out_found_payload = 64'(fp_r);
  assign out_slot          = 10'(slot_r);
endmodule

/* hw/rtl/linear_probe_hash_table.sv */
// Linear probing hash table: insert/update or look up a 32-bit key.
// Each command is hashed a key byte at a time, queued, then the back end reads
// and checks each probed slot in turn before the result. The front end takes a
// new command while the back end still probes an earlier one; busy holds the
// sender off while the queue is full. Result strobes for one cycle and cannot
// be stalled. After reset a clearing pass over all SLOTS slots runs, busy high.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int unsigned SLOTS        = SLOTS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int unsigned IDX_W       = $clog2(SLOTS),
  localparam int unsigned CNT_W       = $clog2(SLOTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_operation,
  input  logic [KEY_W-1:0]        in_key,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [63:0]             out_found_payload,
  output logic [9:0]              out_slot,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);
  logic [CFG_W-1:0]        cap_r, limit_r;
  logic [CNT_W-1:0]        cap;
  logic                    fe_ready, q_push, q_full, q_pop, q_empty, clearing;
  logic                    f_op, b_op;
  logic [KEY_W-1:0]        f_key, b_key;
  logic [PAYLOAD_BITS-1:0] f_pay, b_pay;
  logic [IDX_W-1:0]        f_home, b_home;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAPACITY: cap_r   <= cfg_data;
        CFG_LIMIT:    limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp capacity to 1..SLOTS
  always_comb begin
    if (cap_r == '0)                          cap = CNT_W'(1);
    else if (32'(cap_r) > SLOTS)              cap = CNT_W'(SLOTS);
    else                                      cap = CNT_W'(cap_r);
  end

  assign busy = !fe_ready || clearing;

  lph_front #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .clk, .rst_n, .start(start && !clearing), .fe_ready,
    .in_operation, .in_key, .in_payload, .cap,
    .q_push, .q_full, .q_op(f_op), .q_key(f_key), .q_payload(f_pay), .q_home(f_home)
  );

  lph_queue #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata({f_op, f_key, f_pay, f_home}), .full(q_full),
    .pop(q_pop), .rdata({b_op, b_key, b_pay, b_home}), .empty(q_empty)
  );

  lph_back #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk, .rst_n, .cap, .load_limit(limit_r), .q_empty, .q_pop,
    .q_op(b_op), .q_key(b_key), .q_payload(b_pay), .q_home(b_home), .clearing,
    .out_valid, .out_status, .out_found_payload, .out_slot
  );
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for linear_probe_hash_table: directed table, then random phases.
// Depends on lph_pkg and the linear_probe_hash_table RTL only.
`timescale 1ns / 100ps

module tb_top;
  import lph_pkg::*;

  localparam int unsigned NSLOTS     = SLOTS_DEF;
  localparam int          IDLE_LIMIT = 30000;
  localparam int          PHASES     = 10;
  localparam int          PER_PHASE  = 105;

  typedef enum logic { ROW_XFER, ROW_REG } row_kind_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_payload;
    logic [9:0]  slot;
  } lookup_res_t;

  typedef struct {
    row_kind_t   kind;
    logic        op;
    logic [31:0] key;
    logic [63:0] pay;
    logic        typed;
    lookup_res_t res;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [KEY_W-1:0]  in_key;
  logic [63:0]       in_payload;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [63:0]       out_found_payload;
  logic [9:0]        out_slot;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // Shadow copy of the table
  logic [31:0]       sh_key [NSLOTS];
  logic [63:0]       sh_pay [NSLOTS];
  logic              sh_vld [NSLOTS];
  int unsigned       sh_count;
  logic [CFG_W-1:0]  sh_cap;
  logic [CFG_W-1:0]  sh_limit;

  lookup_res_t       pending_q[$];
  row_t              dir_rows[$];
  int                errors;
  int                idle_cycles;

  linear_probe_hash_table u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found_payload (out_found_payload),
    .out_slot          (out_slot),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned slots_in_use();
    if (sh_cap == 0) return 1;
    if (sh_cap > NSLOTS) return NSLOTS;
    return sh_cap;
  endfunction

  // Work out the result of one transfer and update the shadow table
  function automatic lookup_res_t table_access(logic op, logic [31:0] key, logic [63:0] pay);
    lookup_res_t r;
    int unsigned cap;
    int unsigned h;
    int unsigned s;
    bit          hit;
    cap = slots_in_use();
    h   = 0;
    hit = 0;
    r   = '0;
    for (int i = 0; i < 4; i++) h = (h * HASH_MULT + ((key >> (8 * i)) & 8'hff)) % cap;
    s = h;
    for (int n = 0; n < cap; n++) begin
      if (!sh_vld[s] || sh_key[s] == key) begin
        hit = 1;
        break;
      end
      s = (s + 1) % cap;
    end
    if (op == OP_LOOKUP) begin
      if (hit && sh_vld[s]) begin
        r.status        = ST_FOUND;
        r.found_payload = sh_pay[s];
        r.slot          = s[9:0];
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (hit && sh_vld[s]) begin
      sh_pay[s]       = pay;
      r.status        = ST_UPDATED;
      r.found_payload = pay;
      r.slot          = s[9:0];
    end else if (hit && sh_count < sh_limit) begin
      sh_key[s] = key;
      sh_pay[s] = pay;
      sh_vld[s] = 1'b1;
      sh_count  = (sh_count + 1) & 11'h7ff;
      r.status  = ST_INSERTED;
      r.slot    = s[9:0];
    end else begin
      r.status = ST_FULL;
    end
    return r;
  endfunction

  task automatic add_xfer(logic op, logic [31:0] key, logic [63:0] pay);
    dir_rows.push_back('{ROW_XFER, op, key, pay, 1'b0, '0});
  endtask

  task automatic add_typed(logic op, logic [31:0] key, logic [63:0] pay, lookup_res_t r);
    dir_rows.push_back('{ROW_XFER, op, key, pay, 1'b1, r});
  endtask

  task automatic add_reg(logic idx, logic [CFG_W-1:0] val);
    dir_rows.push_back('{ROW_REG, idx, {21'd0, val}, '0, 1'b0, '0});
  endtask

  // Leaves start high on return; the caller either sends again, pauses or drains
  task automatic send(logic op, logic [31:0] key, logic [63:0] pay, bit typed, lookup_res_t r);
    lookup_res_t predicted;
    start        <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_payload   <= pay;
    do @(posedge clk); while (busy);
    predicted = table_access(op, key, pay);
    pending_q.push_back(typed ? r : predicted);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CAPACITY) sh_cap = val;
    else sh_limit = val;
    @(posedge clk);
  endtask

  // Results cannot be held off: check every strobe
  always @(posedge clk) begin
    lookup_res_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", out_status, out_slot);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          errors++;
        end
        if (out_found_payload !== e.found_payload) begin
          $error("found_payload: expected %h, actual %h", e.found_payload, out_found_payload);
          errors++;
        end
        if (out_slot !== e.slot) begin
          $error("slot: expected %0d, actual %0d", e.slot, out_slot);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] pool [24];
    logic [CFG_W-1:0] caps   [8];
    logic [CFG_W-1:0] limits [8];
    int          burst_left;
    bit          gaps_on;
    logic        op;
    logic [31:0] key;
    row_t        rw;

    errors       = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = 1'b0;
    in_key       = '0;
    in_payload   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = 1'b0;
    cfg_data     = '0;
    sh_count     = 0;
    sh_cap       = CAP_RESET;
    sh_limit     = LIMIT_RESET;
    for (int i = 0; i < NSLOTS; i++) begin
      sh_vld[i] = 1'b0;
      sh_key[i] = '0;
      sh_pay[i] = '0;
    end

    // After reset, extremes, capacity forced to one slot with no room, then cap 4/limit 3, 2047
    add_typed(OP_LOOKUP, 32'h0, 64'h0, '{ST_NOT_FOUND, 64'h0, 10'd0});
    add_typed(OP_INSERT, 32'h0, '1, '{ST_INSERTED, 64'h0, 10'd0});
    add_typed(OP_LOOKUP, 32'h0, 64'h0, '{ST_FOUND, '1, 10'd0});
    add_typed(OP_INSERT, 32'h0, 64'h0, '{ST_UPDATED, 64'h0, 10'd0});
    add_xfer(OP_INSERT, 32'hffff_ffff, 64'h5555_5555_aaaa_aaaa);
    add_xfer(OP_LOOKUP, 32'hffff_ffff, 64'h0);
    add_xfer(OP_INSERT, 32'h0000_0400, 64'haaaa_aaaa_5555_5555);
    add_xfer(OP_LOOKUP, 32'h0000_0400, 64'h0);
    add_reg(CFG_CAPACITY, 11'd0);
    add_reg(CFG_LIMIT, 11'd0);
    add_xfer(OP_INSERT, 32'h0, 64'h1234_5678_9abc_def0);
    add_typed(OP_INSERT, 32'h1, 64'h1, '{ST_FULL, 64'h0, 10'd0});
    add_typed(OP_LOOKUP, 32'h1, 64'h0, '{ST_NOT_FOUND, 64'h0, 10'd0});
    add_reg(CFG_CAPACITY, 11'd4);
    add_reg(CFG_LIMIT, 11'd3);
    add_xfer(OP_INSERT, 32'h0a00_0001, 64'h11);
    add_xfer(OP_INSERT, 32'h0a00_0002, 64'h22);
    add_xfer(OP_INSERT, 32'h0a00_0003, 64'h33);
    add_xfer(OP_INSERT, 32'h0a00_0004, 64'h44);
    add_xfer(OP_LOOKUP, 32'h0a00_0003, 64'h0);
    add_reg(CFG_CAPACITY, 11'd2047);
    add_reg(CFG_LIMIT, 11'd2047);
    add_xfer(OP_LOOKUP, 32'h0a00_0002, 64'h0);
    add_xfer(OP_INSERT, 32'hc0a8_0101, 64'hdead_beef_0000_0001);
    add_xfer(OP_LOOKUP, 32'hc0a8_0101, 64'h0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      if (rw.kind == ROW_REG) begin
        drain();
        write_reg(rw.op, rw.key[CFG_W-1:0]);
      end else begin
        send(rw.op, rw.key, rw.pay, rw.typed, rw.res);
      end
    end

    caps   = '{11'd1, 11'd4, 11'd16, 11'd1024, 11'd0, 11'd2047, 11'd100, 11'd37};
    limits = '{11'd1, 11'd3, 11'd16, 11'd1024, 11'd0, 11'd2047, 11'd50, 11'd768};
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 8) begin
        write_reg(CFG_CAPACITY, caps[p]);
        write_reg(CFG_LIMIT, limits[p]);
      end else begin
        write_reg(CFG_CAPACITY, CFG_W'($urandom_range(1, 1024)));
        write_reg(CFG_LIMIT, CFG_W'($urandom_range(1, 1024)));
      end
      foreach (pool[i]) pool[i] = $urandom;
      gaps_on    = (p % 3 != 1);
      burst_left = $urandom_range(1, 30);
      for (int n = 0; n < PER_PHASE; n++) begin
        if (p == 2 && n == 50) drain();
        op  = ($urandom_range(0, 9) < 6) ? OP_INSERT : OP_LOOKUP;
        key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 23)] : $urandom;
        send(op, key, {$urandom, $urandom}, 1'b0, '0);
        if (gaps_on) begin
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            pause($urandom_range(1, 15));
            burst_left = $urandom_range(1, 30);
          end
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
